>>> rtl/core/mcsg_pkg.sv
// mcsg_pkg: shared types, codes and constants of the midi clock sync generator
// no dependencies
`timescale 1ns / 1ps
package mcsg_pkg;

  localparam int unsigned CPB_DEF = 24;
  localparam int unsigned TPS_DEF = 1000000;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;

  typedef enum logic [2:0] {
    CFG_CHANNEL = 3'd0,
    CFG_MSB_CC  = 3'd1,
    CFG_LSB_CC  = 3'd2,
    CFG_CC_EN   = 3'd3,
    CFG_OUT_EN  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_CONTINUE = 3'd3,
    OP_TEMPO    = 3'd4,
    OP_DECK     = 3'd5,
    OP_CC       = 3'd6,
    OP_SONGPOS  = 3'd7
  } op_e;

  // real-time and system common status bytes, and the control change status nibble
  localparam logic [7:0] RT_CLOCK      = 8'hF8;
  localparam logic [7:0] RT_START      = 8'hFA;
  localparam logic [7:0] RT_CONTINUE   = 8'hFB;
  localparam logic [7:0] RT_STOP       = 8'hFC;
  localparam logic [7:0] MIDI_SONGPOS  = 8'hF2;
  localparam logic [3:0] MIDI_CC_HI    = 4'hB;

  localparam logic [15:0] BPM_MIN    = 16'd2000;
  localparam logic [15:0] BPM_MAX    = 16'd30000;
  localparam logic [15:0] CC_BPM_MIN = 16'd6000;
  localparam logic [15:0] CC_BPM_MAX = 16'd18727;
  localparam logic [16:0] RETUNE_TOL = 17'd10;
  localparam logic [17:0] PHASE_TOL  = 18'd1310;

  localparam logic [15:0] TEMPO_RST  = 16'd12000;
  localparam logic [16:0] PERIOD_RST = 17'd20833;
  localparam logic [16:0] PERIOD_MAX = 17'h1FFFF;

  // floor(x/5) == (x*RECIP5) >> 18 for x below 2^16
  localparam logic [15:0] RECIP5 = 16'd52429;

  typedef struct packed {
    op_e         op;
    logic [15:0] bpm;
    logic [14:0] bpm_clamp;
    logic [13:0] cc_tempo;
    logic        playing;
    logic [15:0] phase;
    logic        phase_valid;
    logic [6:0]  cc_number;
    logic [6:0]  cc_value;
    logic [13:0] song_pos;
  } cmd_t;

endpackage

>>> rtl/core/mcsg_if.sv
// mcsg_in_if / mcsg_out_if: valid-ready channels of the midi clock sync generator
// no dependencies
`timescale 1ns / 1ps
interface mcsg_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [15:0] bpm_centi;
  logic        deck_playing;
  logic [15:0] deck_phase;
  logic        phase_valid;
  logic [6:0]  cc_number;
  logic [6:0]  cc_value;
  logic [13:0] song_position;
  modport source (output valid, opcode, bpm_centi, deck_playing, deck_phase, phase_valid,
                  cc_number, cc_value, song_position, input ready);
  modport sink (input valid, opcode, bpm_centi, deck_playing, deck_phase, phase_valid,
                cc_number, cc_value, song_position, output ready);
endinterface

interface mcsg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] midi_byte;
  logic       last_byte;
  modport source (output valid, midi_byte, last_byte, input ready);
  modport sink (input valid, midi_byte, last_byte, output ready);
endinterface

>>> rtl/core/mcsg_front.sv
// mcsg_front: accepts input requests, pre-clamps tempo fields, two-entry command queue
// depends on mcsg_pkg, mcsg_if
`timescale 1ns / 1ps
module mcsg_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  mcsg_in_if.sink       in_ch,
  output logic          cmd_valid_o,
  output mcsg_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import mcsg_pkg::*;

  cmd_t        queue_q [2];
  cmd_t        cmd_new;
  logic        wp_q, wp_d, rp_q, rp_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  logic [15:0] bc, bcc;

  // classify and clamp
  always_comb begin
    bc  = in_ch.bpm_centi;
    bcc = in_ch.bpm_centi;
    if (bc < BPM_MIN) bc = BPM_MIN;
    if (bc > BPM_MAX) bc = BPM_MAX;
    if (bcc < CC_BPM_MIN) bcc = CC_BPM_MIN;
    if (bcc > CC_BPM_MAX) bcc = CC_BPM_MAX;
    cmd_new.op          = op_e'(in_ch.opcode);
    cmd_new.bpm         = in_ch.bpm_centi;
    cmd_new.bpm_clamp   = bc[14:0];
    cmd_new.cc_tempo    = 14'(bcc - CC_BPM_MIN);
    cmd_new.playing     = in_ch.deck_playing;
    cmd_new.phase       = in_ch.deck_phase;
    cmd_new.phase_valid = in_ch.phase_valid;
    cmd_new.cc_number   = in_ch.cc_number;
    cmd_new.cc_value    = in_ch.cc_value;
    cmd_new.song_pos    = in_ch.song_position;
  end

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = queue_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wp_q] <= cmd_new;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end
endmodule

>>> rtl/core/mcsg_back.sv
// mcsg_back: executes commands, keeps transport state, period divider, phase nudge, byte output
// depends on mcsg_pkg, mcsg_if
`timescale 1ns / 1ps
module mcsg_back #(
  parameter int unsigned CLOCKS_PER_BEAT  = mcsg_pkg::CPB_DEF,
  parameter int unsigned TICKS_PER_SECOND = mcsg_pkg::TPS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  input  mcsg_pkg::cmd_t                    cmd_i,
  output logic                              cmd_pop_o,
  input  logic                              cfg_we_i,
  input  logic [mcsg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mcsg_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  mcsg_out_if.source                        out_ch
);
  import mcsg_pkg::*;

  localparam longint unsigned NUM = longint'(TICKS_PER_SECOND) * 6000;
  localparam int unsigned NW  = $clog2(NUM + 1);
  localparam int unsigned CW  = $clog2(NW);
  localparam int unsigned DW  = $clog2(CLOCKS_PER_BEAT * 30000 + 1);
  localparam logic [NW-1:0] NUM_V = NW'(NUM);
  localparam int unsigned MW  = $clog2(CLOCKS_PER_BEAT + 1);
  localparam logic [16:0] PH_STEP = 17'(65536 / CLOCKS_PER_BEAT);
  localparam logic [MW:0] PH_REM  = (MW + 1)'(65536 % CLOCKS_PER_BEAT);
  localparam logic [MW:0] CPB_V   = (MW + 1)'(CLOCKS_PER_BEAT);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_NUD1 = 6'b000100,
    S_NUD2 = 6'b001000,
    S_NUD3 = 6'b010000,
    S_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [3:0] ch_q;
  logic [6:0] msb_q, lsb_q;
  logic       cce_q, oe_q;

  // transport state
  logic        run_q, run_d;
  logic [15:0] tempo_q, tempo_d;
  logic [16:0] nom_q, nom_d, act_q, act_d, tick_q, tick_d;
  logic [31:0] pulse_q, pulse_d;
  logic        sync_q, sync_d;
  logic [MW-1:0] pmod_q, pmod_d;
  logic [16:0] pacc_q, pacc_d;
  logic [MW:0] prem_q, prem_d;

  // work registers
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          nud_q, nud_d;
  logic [15:0]   phase_q, phase_d;
  logic [32:0]   prod_q, prod_d;
  logic          neg_q, neg_d;
  logic [12:0]   f_q, f_d;
  logic [13:0]   adj_q, adj_d;
  logic [17:0]   lo_q, lo_d, hi_q, hi_d;

  // byte list
  logic [7:0] bytes_q [7];
  logic [7:0] bytes_d [7];
  logic [2:0] n_q, n_d, idx_q, idx_d;

  // output register
  logic       ov_q, ov_d, olast_q, olast_d;
  logic [7:0] obyte_q, obyte_d;

  logic [7:0]  ccb [6];
  logic [7:0]  st_byte;
  logic [16:0] tc, bdiff;
  logic [DW:0] trial;
  logic        qbit;
  logic [NW-1:0] qn;
  logic signed [17:0] err;
  logic [15:0] emag;
  logic [30:0] fm, am;
  logic [17:0] r20;
  logic signed [18:0] pv;
  logic [17:0] pc;
  logic        ld;

  always_comb begin
    st_byte = {MIDI_CC_HI, ch_q};
    ccb[0] = st_byte;
    ccb[1] = {1'b0, msb_q};
    ccb[2] = {1'b0, cmd_i.cc_tempo[13:7]};
    ccb[3] = st_byte;
    ccb[4] = {1'b0, lsb_q};
    ccb[5] = {1'b0, cmd_i.cc_tempo[6:0]};
  end

  assign tc    = tick_q + 17'd1;
  assign bdiff = (cmd_i.bpm > tempo_q) ? 17'(cmd_i.bpm - tempo_q) : 17'(tempo_q - cmd_i.bpm);

  // divider step
  assign trial = {rem_q[DW-1:0], NUM_V[cnt_q]};
  assign qbit  = (trial >= {1'b0, dvs_q});
  assign qn    = {quo_q[NW-2:0], qbit};

  // phase error against expected position in the beat
  always_comb begin
    err = $signed({2'b00, phase_q}) - $signed({1'b0, pacc_q});
    if (err < -18'sd32768) err = err + 18'sd65536;
    else if (err > 18'sd32768) err = err - 18'sd65536;
    emag = err[17] ? 16'(-err) : err[15:0];
  end

  assign fm  = 31'(nom_q[16:2]) * 31'(RECIP5);
  assign am  = 31'(prod_q[32:18]) * 31'(RECIP5);
  assign r20 = 18'(nom_q) - 18'({f_q, 4'b0}) - 18'({f_q, 2'b0});
  assign ld  = (state_q == S_EMIT) && oe_q && (idx_q != n_q) && (!ov_q || out_ch.ready);

  always_comb begin
    state_d = state_q;
    run_d = run_q; tempo_d = tempo_q; nom_d = nom_q; act_d = act_q; tick_d = tick_q;
    pulse_d = pulse_q; sync_d = sync_q; pmod_d = pmod_q; pacc_d = pacc_q; prem_d = prem_q;
    dvs_d = dvs_q; rem_d = rem_q; quo_d = quo_q; cnt_d = cnt_q; nud_d = nud_q;
    phase_d = phase_q; prod_d = prod_q; neg_d = neg_q; f_d = f_q; adj_d = adj_q;
    lo_d = lo_q; hi_d = hi_q;
    bytes_d = bytes_q; n_d = n_q; idx_d = idx_q;
    cmd_pop_o = 1'b0;
    pv = '0;
    pc = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          idx_d     = 3'd0;
          n_d       = 3'd0;
          state_d   = S_EMIT;
          phase_d   = cmd_i.phase;
          nud_d     = 1'b0;
          dvs_d     = DW'(CLOCKS_PER_BEAT) * DW'(cmd_i.bpm_clamp);
          rem_d     = '0;
          quo_d     = '0;
          cnt_d     = CW'(NW - 1);
          unique case (cmd_i.op)
            OP_TICK: begin
              if (run_q) begin
                if (tc >= act_q) begin
                  tick_d     = '0;
                  pulse_d    = pulse_q + 32'd1;
                  bytes_d[0] = RT_CLOCK;
                  n_d        = 3'd1;
                  if (pulse_q == '1 || pmod_q == MW'(CLOCKS_PER_BEAT - 1)) begin
                    pmod_d = '0; pacc_d = '0; prem_d = '0;
                  end else begin
                    pmod_d = pmod_q + MW'(1);
                    if (prem_q + PH_REM >= CPB_V) begin
                      prem_d = prem_q + PH_REM - CPB_V;
                      pacc_d = pacc_q + PH_STEP + 17'd1;
                    end else begin
                      prem_d = prem_q + PH_REM;
                      pacc_d = pacc_q + PH_STEP;
                    end
                  end
                end else begin
                  tick_d = tc;
                end
              end
            end
            OP_START: begin
              tempo_d = cmd_i.bpm; tick_d = '0; pulse_d = '0;
              pmod_d = '0; pacc_d = '0; prem_d = '0; run_d = 1'b1;
              bytes_d[0] = RT_START;
              n_d = 3'd1;
              if (cce_q) begin
                for (int k = 0; k < 6; k++) bytes_d[k + 1] = ccb[k];
                n_d = 3'd7;
              end
              state_d = S_DIV;
            end
            OP_STOP: begin
              run_d = 1'b0; bytes_d[0] = RT_STOP; n_d = 3'd1;
            end
            OP_CONTINUE: begin
              tick_d = '0; act_d = nom_q; run_d = 1'b1;
              bytes_d[0] = RT_CONTINUE; n_d = 3'd1;
            end
            OP_TEMPO: begin
              tempo_d = 16'(cmd_i.bpm_clamp); tick_d = '0;
              if (cce_q) begin
                for (int k = 0; k < 6; k++) bytes_d[k] = ccb[k];
                n_d = 3'd6;
              end
              state_d = S_DIV;
            end
            OP_DECK: begin
              if (cmd_i.playing && !run_q) begin
                // deck started: same as start
                tempo_d = cmd_i.bpm; tick_d = '0; pulse_d = '0;
                pmod_d = '0; pacc_d = '0; prem_d = '0; run_d = 1'b1;
                bytes_d[0] = RT_START;
                n_d = 3'd1;
                if (cce_q) begin
                  for (int k = 0; k < 6; k++) bytes_d[k + 1] = ccb[k];
                  n_d = 3'd7;
                end
                state_d = S_DIV;
              end else if (!cmd_i.playing && run_q) begin
                run_d = 1'b0; bytes_d[0] = RT_STOP; n_d = 3'd1;
              end else if (run_q) begin
                sync_d = 1'b1;
                nud_d  = cmd_i.phase_valid && sync_q;
                if (bdiff > RETUNE_TOL) begin
                  tempo_d = cmd_i.bpm; tick_d = '0;
                  if (cce_q) begin
                    for (int k = 0; k < 6; k++) bytes_d[k] = ccb[k];
                    n_d = 3'd6;
                  end
                  state_d = S_DIV;
                end else if (cmd_i.phase_valid && sync_q) begin
                  state_d = S_NUD1;
                end
              end
            end
            OP_CC: begin
              bytes_d[0] = st_byte;
              bytes_d[1] = {1'b0, cmd_i.cc_number};
              bytes_d[2] = {1'b0, cmd_i.cc_value};
              n_d = 3'd3;
            end
            OP_SONGPOS: begin
              bytes_d[0] = MIDI_SONGPOS;
              bytes_d[1] = {1'b0, cmd_i.song_pos[6:0]};
              bytes_d[2] = {1'b0, cmd_i.song_pos[13:7]};
              n_d = 3'd3;
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_d = qbit ? (trial - {1'b0, dvs_q}) : trial;
        quo_d = qn;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (qn > NW'(PERIOD_MAX)) nom_d = PERIOD_MAX;
          else if (qn == '0) nom_d = 17'd1;
          else nom_d = qn[16:0];
          act_d   = nom_d;
          state_d = nud_q ? S_NUD1 : S_EMIT;
        end
      end
      S_NUD1: begin
        prod_d = 33'(emag) * 33'(nom_q);
        neg_d  = err[17];
        f_d    = fm[30:18];
        state_d = (err > $signed(PHASE_TOL) || err < -$signed(PHASE_TOL)) ? S_NUD2 : S_EMIT;
      end
      S_NUD2: begin
        adj_d = 14'(am[30:18]);
        hi_d  = 18'(nom_q) + 18'(f_q);
        lo_d  = 18'(nom_q) - 18'(f_q) - ((r20 != '0) ? 18'd1 : 18'd0);
        state_d = S_NUD3;
      end
      S_NUD3: begin
        pv = neg_q ? ($signed({2'b00, nom_q}) + $signed({5'b0, adj_q}))
                   : ($signed({2'b00, nom_q}) - $signed({5'b0, adj_q}));
        if (pv < $signed({1'b0, lo_q})) pc = lo_q;
        else if (pv > $signed({1'b0, hi_q})) pc = hi_q;
        else pc = pv[17:0];
        if (pc != 18'(nom_q)) begin
          act_d  = (pc[16:0] == '0) ? 17'd1 : pc[16:0];
          tick_d = '0;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!oe_q || idx_q == n_q) state_d = S_IDLE;
        else if (ld) idx_d = idx_q + 3'd1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d    = ov_q;
    obyte_d = obyte_q;
    olast_d = olast_q;
    if (ld) begin
      ov_d    = 1'b1;
      obyte_d = bytes_q[idx_q];
      olast_d = (idx_q == n_q - 3'd1);
    end else if (out_ch.ready) begin
      ov_d = 1'b0;
    end
  end

  assign out_ch.valid     = ov_q;
  assign out_ch.midi_byte = obyte_q;
  assign out_ch.last_byte = olast_q;

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d; rem_q <= rem_d; quo_q <= quo_d; cnt_q <= cnt_d;
    phase_q <= phase_d; prod_q <= prod_d; neg_q <= neg_d; f_q <= f_d;
    adj_q <= adj_d; lo_q <= lo_d; hi_q <= hi_d;
    bytes_q <= bytes_d; obyte_q <= obyte_d; olast_q <= olast_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q <= '0; msb_q <= '0; lsb_q <= 7'd32; cce_q <= 1'b0; oe_q <= 1'b1;
      run_q <= 1'b0; tempo_q <= TEMPO_RST; nom_q <= PERIOD_RST; act_q <= PERIOD_RST;
      tick_q <= '0; pulse_q <= '0; sync_q <= 1'b0;
      pmod_q <= '0; pacc_q <= '0; prem_q <= '0;
      nud_q <= 1'b0; n_q <= '0; idx_q <= '0; ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_CHANNEL: ch_q  <= cfg_data_i[3:0];
          CFG_MSB_CC:  msb_q <= cfg_data_i;
          CFG_LSB_CC:  lsb_q <= cfg_data_i;
          CFG_CC_EN:   cce_q <= cfg_data_i[0];
          CFG_OUT_EN:  oe_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      run_q <= run_d; tempo_q <= tempo_d; nom_q <= nom_d; act_q <= act_d;
      tick_q <= tick_d; pulse_q <= pulse_d; sync_q <= sync_d;
      pmod_q <= pmod_d; pacc_q <= pacc_d; prem_q <= prem_d;
      nud_q <= nud_d; n_q <= n_d; idx_q <= idx_d; ov_q <= ov_d;
    end
  end
endmodule

>>> rtl/core/midi_clock_sync_generator_unit.sv
// midi_clock_sync_generator_unit: top level, front queue plus execution back end
// depends on mcsg_pkg, mcsg_if, mcsg_front, mcsg_back
//
//  channel | dir | handshake           | payload
//  in_ch   | in  | valid/ready         | opcode, bpm_centi, deck fields, cc fields, song_position
//  out_ch  | out | valid/ready         | midi_byte, last_byte
//  cfg     | in  | cfg_we_i, no stall  | cfg_idx_i, cfg_data_i
//
// the back end emits a request's bytes one per cycle while out_ch is ready, then goes idle
// tempo requests (start, set tempo, deck start or retune) also run the restoring period
// divider, one quotient bit per cycle; the quotient is 33 bits wide at the default tick rate
// a deck phase nudge adds multiply and clamp states S_NUD1-S_NUD3, only S_NUD1 on a small error
// reset is asynchronous, active low; state returns to stopped at 120.00 bpm
// the two-entry queue keeps accepting while the back end stalls on out_ch, until it is full
`timescale 1ns / 1ps
module midi_clock_sync_generator_unit #(
  parameter int unsigned CLOCKS_PER_BEAT  = mcsg_pkg::CPB_DEF,
  parameter int unsigned TICKS_PER_SECOND = mcsg_pkg::TPS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mcsg_in_if.sink                         in_ch,
  mcsg_out_if.source                      out_ch,
  input  logic                            cfg_we_i,
  input  logic [mcsg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mcsg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mcsg_pkg::*;

  // queued commands between front and back
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  mcsg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mcsg_back #(
    .CLOCKS_PER_BEAT  (CLOCKS_PER_BEAT),
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .out_ch      (out_ch)
  );
endmodule
